/* design/morse_time_digit_keyer_core_assert.svh */
// ----------------------------------------------------------------------------
// Morse time digit keyer: assertion macros
// Shared same-cycle-implication and next-cycle-implication forms.
// ----------------------------------------------------------------------------
`ifndef MORSE_TIME_DIGIT_KEYER_CORE_ASSERT_SVH
`define MORSE_TIME_DIGIT_KEYER_CORE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MTDK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtdk assertion failed");

// next-cycle implication, quiet during reset
`define MTDK_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtdk assertion failed");

`endif

/* design/mtdk_pkg.sv */
// ----------------------------------------------------------------------------
// Morse time digit keyer: package
// Shared types, register indexes and the Morse element table.
// ----------------------------------------------------------------------------
package mtdk_pkg;

   localparam int CNT_W         = 20;
   localparam int DIT_W         = 16;
   localparam int UNITS_W       = 4;
   localparam int CSR_IDX_W     = 2;
   localparam int ELEM_W        = 3;
   localparam int ELEMENT_COUNT = 5;
   localparam int STORED_DIGITS = 4;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_MARK = 2'd1,
      PH_GAP  = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIT_TICKS = 2'd0,
      CSR_DAH_UNITS = 2'd1,
      CSR_GAP_UNITS = 2'd2
   } csr_idx_type;

   // lengths in ticks, kept ready for the sequencer
   typedef struct packed {
      logic [CNT_W-1:0] dit_len;
      logic [CNT_W-1:0] dah_len;
      logic [CNT_W-1:0] gap_len;
   } mtdk_len_type;

   typedef struct packed {
      logic key;
      logic busy;
      logic done;
      logic rejected;
   } mtdk_res_type;

   // bit e set: element e of the digit is a dah
   localparam logic [7:0] DAH_MASK [16] = '{
      8'h1F, 8'h1E, 8'h1C, 8'h18, 8'h10, 8'h00, 8'h01, 8'h03,
      8'h07, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

endpackage

/* design/mtdk_seq.sv */
// ----------------------------------------------------------------------------
// Morse time digit keyer: element sequencer
// Holds phase, tick count, element and digit position and the latched digits;
// one step per accepted item.
// ----------------------------------------------------------------------------
module mtdk_seq #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       op,
   input  logic [5:0]                 hours_bcd,
   input  logic [6:0]                 minutes_bcd,
   input  mtdk_pkg::mtdk_len_type     lens,
   output mtdk_pkg::mtdk_res_type     res
);

   localparam int DIG_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   mtdk_pkg::phase_type             phase_ff, phase_in;
   logic [mtdk_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [mtdk_pkg::ELEM_W-1:0]     elem_ff, elem_in;
   logic [DIG_W-1:0]                digit_ff, digit_in;
   logic [3:0]                      store_ff [mtdk_pkg::STORED_DIGITS];

   logic                            load;
   logic                            bad_nibble;
   logic [2:0]                      digit_x;
   logic [3:0]                      cur_digit;
   logic [7:0]                      cur_mask;
   logic [mtdk_pkg::CNT_W-1:0]      mark_len;
   logic [mtdk_pkg::CNT_W-1:0]      count_inc;
   logic                            done;

   assign bad_nibble = (hours_bcd[3:0] > 4'd9) || (minutes_bcd[3:0] > 4'd9);

   // digits past the fourth are sent as zero
   assign digit_x   = 3'(digit_ff);
   assign cur_digit = digit_x[2] ? 4'd0 : store_ff[digit_x[1:0]];
   assign cur_mask  = mtdk_pkg::DAH_MASK[cur_digit];
   assign mark_len  = cur_mask[elem_ff] ? lens.dah_len : lens.dit_len;
   assign count_inc = count_ff + 1'b1;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      elem_in  = elem_ff;
      digit_in = digit_ff;
      load     = 1'b0;
      done     = 1'b0;
      res      = '0;
      if (op) begin
         if (phase_ff != mtdk_pkg::PH_IDLE || bad_nibble) begin
            res.rejected = 1'b1;
         end else begin
            load     = 1'b1;
            phase_in = mtdk_pkg::PH_MARK;
            count_in = '0;
            elem_in  = '0;
            digit_in = '0;
         end
      end else begin
         case (phase_ff)
            mtdk_pkg::PH_MARK: begin
               count_in = count_inc;
               if (count_inc >= mark_len) begin
                  phase_in = mtdk_pkg::PH_GAP;
                  count_in = '0;
               end
            end
            mtdk_pkg::PH_GAP: begin
               count_in = count_inc;
               if (count_inc >= lens.gap_len) begin
                  count_in = '0;
                  if (elem_ff != mtdk_pkg::ELEM_W'(mtdk_pkg::ELEMENT_COUNT - 1)) begin
                     elem_in  = elem_ff + 1'b1;
                     phase_in = mtdk_pkg::PH_MARK;
                  end else if (digit_ff != DIG_W'(DIGIT_COUNT - 1)) begin
                     elem_in  = '0;
                     digit_in = digit_ff + 1'b1;
                     phase_in = mtdk_pkg::PH_MARK;
                  end else begin
                     elem_in  = '0;
                     digit_in = '0;
                     phase_in = mtdk_pkg::PH_IDLE;
                     done     = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = mtdk_pkg::PH_IDLE;
            end
         endcase
      end
      res.key  = (phase_in == mtdk_pkg::PH_MARK);
      res.busy = (phase_in != mtdk_pkg::PH_IDLE);
      res.done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mtdk_pkg::PH_IDLE;
         count_ff <= '0;
         elem_ff  <= '0;
         digit_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         elem_ff  <= elem_in;
         digit_ff <= digit_in;
      end
   end

   // latched digits: hours tens, hours units, minutes tens, minutes units
   always_ff @(posedge clock) begin
      if (step && load) begin
         store_ff[0] <= {2'b00, hours_bcd[5:4]};
         store_ff[1] <= hours_bcd[3:0];
         store_ff[2] <= {1'b0, minutes_bcd[6:4]};
         store_ff[3] <= minutes_bcd[3:0];
      end
   end

endmodule

/* design/morse_time_digit_keyer_core.sv */
// ----------------------------------------------------------------------------
// Morse time digit keyer core
// Sends a BCD time as Morse digits on a key line, one tick item at a time.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the result side does not stall. Each
// item goes through an input register, one pass of the element sequencer, and
// a result register that drives the result ports. The sequencer's
// count-and-compare step is combinational between the two registers. Mark and
// gap lengths in ticks are products of the timing registers, formed at the
// configuration write and held, so a write is in force for the very next item.
module morse_time_digit_keyer_core #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [5:0]  req_hours_bcd,
   input  logic [6:0]  req_minutes_bcd,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_key,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_rejected,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic                                 in_vld_ff;
   logic                                 op_ff;
   logic [5:0]                           hrs_ff;
   logic [6:0]                           mins_ff;

   logic                                 rsp_vld_ff;
   mtdk_pkg::mtdk_res_type               res_ff, res_in;

   logic [mtdk_pkg::DIT_W-1:0]           dit_ff;
   logic [mtdk_pkg::UNITS_W-1:0]         dah_units_ff;
   logic [mtdk_pkg::UNITS_W-1:0]         gap_units_ff;
   logic [mtdk_pkg::CNT_W-1:0]           dah_len_ff;
   logic [mtdk_pkg::CNT_W-1:0]           gap_len_ff;
   mtdk_pkg::mtdk_len_type               lens;

   logic                                 advance;
   logic                                 req_beat;
   logic [mtdk_pkg::UNITS_W-1:0]         csr_units;

   assign advance   = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_beat  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_beat) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         op_ff   <= req_op;
         hrs_ff  <= req_hours_bcd;
         mins_ff <= req_minutes_bcd;
      end
   end

   // timing registers and the lengths derived from them
   assign csr_units = csr_wdata[mtdk_pkg::UNITS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dit_ff       <= 16'd60;
         dah_units_ff <= 4'd3;
         gap_units_ff <= 4'd3;
         dah_len_ff   <= 20'd180;
         gap_len_ff   <= 20'd180;
      end else if (csr_we) begin
         case (mtdk_pkg::csr_idx_type'(csr_index))
            mtdk_pkg::CSR_DIT_TICKS: begin
               dit_ff     <= csr_wdata;
               dah_len_ff <= mtdk_pkg::CNT_W'(csr_wdata) * mtdk_pkg::CNT_W'(dah_units_ff);
               gap_len_ff <= mtdk_pkg::CNT_W'(csr_wdata) * mtdk_pkg::CNT_W'(gap_units_ff);
            end
            mtdk_pkg::CSR_DAH_UNITS: begin
               dah_units_ff <= csr_units;
               dah_len_ff   <= mtdk_pkg::CNT_W'(dit_ff) * mtdk_pkg::CNT_W'(csr_units);
            end
            mtdk_pkg::CSR_GAP_UNITS: begin
               gap_units_ff <= csr_units;
               gap_len_ff   <= mtdk_pkg::CNT_W'(dit_ff) * mtdk_pkg::CNT_W'(csr_units);
            end
            default: begin
            end
         endcase
      end
   end

   assign lens.dit_len = mtdk_pkg::CNT_W'(dit_ff);
   assign lens.dah_len = dah_len_ff;
   assign lens.gap_len = gap_len_ff;

   mtdk_seq #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .op          (op_ff),
      .hours_bcd   (hrs_ff),
      .minutes_bcd (mins_ff),
      .lens        (lens),
      .res         (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_key      = res_ff.key;
   assign rsp_busy_res = res_ff.busy;
   assign rsp_done_res = res_ff.done;
   assign rsp_rejected = res_ff.rejected;

endmodule

/* design/mtdk_checker.sv */
// ----------------------------------------------------------------------------
// Morse time digit keyer: port checker
// Watches the top level's ports for result consistency over time.
// ----------------------------------------------------------------------------
`include "morse_time_digit_keyer_core_assert.svh"

module mtdk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_key,
   input logic        rsp_busy_res,
   input logic        rsp_done_res,
   input logic        rsp_rejected
);

   // key only ever up inside a running sequence
   `MTDK_ASSERT_IMP(a_key_busy, clock, reset, rsp_valid && rsp_key, rsp_busy_res)

   // the beat that finishes a sequence leaves it idle
   `MTDK_ASSERT_IMP(a_done_idle, clock, reset, rsp_valid && rsp_done_res,
                    !rsp_busy_res && !rsp_key)

   // a refused start never completes anything
   `MTDK_ASSERT_IMP(a_rej_done, clock, reset, rsp_valid && rsp_rejected, !rsp_done_res)

   // input only backs up behind a held result beat
   `MTDK_ASSERT_IMP(a_req_stall, clock, reset, req_stall, rsp_valid && rsp_stall)

   // stalled result beat is held
   `MTDK_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_key) && $stable(rsp_busy_res)
                    && $stable(rsp_done_res) && $stable(rsp_rejected))

endmodule

bind morse_time_digit_keyer_core mtdk_checker u_mtdk_checker (.*);

/* tb/sv/morse_time_digit_keyer_core_tb.sv */
// ----------------------------------------------------------------------------
// Morse time digit keyer core: testbench
// Drives start and tick beats through several timing settings with random
// gaps and stalls, and checks every result beat against a line predictor.
// ----------------------------------------------------------------------------
module morse_time_digit_keyer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          DIGITS       = 4;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned LIMIT_CYCLES = 500000;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_START = 1'b1
   } keyer_op_type;

   typedef struct packed {
      keyer_op_type op;
      logic [5:0]   hours;
      logic [6:0]   minutes;
   } keyer_item_type;

   typedef struct packed {
      logic [15:0]                dit;
      logic [3:0]                 dah;
      logic [3:0]                 gap;
      mtdk_pkg::phase_type        phase;
      logic [mtdk_pkg::CNT_W-1:0] count;
      logic [2:0]                 element;
      logic [1:0]                 digit;
      logic [3:0][3:0]            digits;
   } keyer_state_type;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_op          = 1'b0;
   logic [5:0]  req_hours_bcd   = '0;
   logic [6:0]  req_minutes_bcd = '0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic        rsp_key;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_rejected;
   logic        csr_we          = 1'b0;
   logic [1:0]  csr_index       = '0;
   logic [15:0] csr_wdata       = '0;

   keyer_item_type         items_to_send [$];
   mtdk_pkg::mtdk_res_type results_due [$];
   keyer_state_type        plan_state;   // advanced as items are queued
   keyer_state_type        line_state;   // advanced as items are accepted

   logic        req_beat      = 1'b0;
   logic        rsp_beat      = 1'b0;
   int unsigned tx_gap_left   = 0;
   int unsigned rx_gap_left   = 0;
   int unsigned rx_hold_left  = 0;
   logic        rx_hold_start = 1'b0;
   bit          tx_burst      = 1'b0;
   bit          rx_burst      = 1'b0;
   int unsigned cycle_count   = 0;
   int unsigned error_count   = 0;
   int unsigned results_seen  = 0;
   int unsigned items_queued  = 0;
   int unsigned starts_taken  = 0;
   int unsigned starts_refused = 0;
   int unsigned sends_done    = 0;
   int unsigned settings_run  = 1;

   string res_field [4] = '{"rejected", "done_res", "busy_res", "key"};

   morse_time_digit_keyer_core #(
      .DIGIT_COUNT (DIGITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_hours_bcd   (req_hours_bcd),
      .req_minutes_bcd (req_minutes_bcd),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key         (rsp_key),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_rejected    (rsp_rejected),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // line predictor
   // ------------------------------------------------------------------------
   function automatic keyer_state_type idle_keyer();
      keyer_state_type s;
      s       = '0;
      s.phase = mtdk_pkg::PH_IDLE;
      s.dit   = 16'd60;
      s.dah   = 4'd3;
      s.gap   = 4'd3;
      return s;
   endfunction

   function automatic void apply_timing(inout keyer_state_type s,
                                        input mtdk_pkg::csr_idx_type idx,
                                        input logic [15:0] val);
      case (idx)
         mtdk_pkg::CSR_DIT_TICKS: s.dit = val;
         mtdk_pkg::CSR_DAH_UNITS: s.dah = val[3:0];
         mtdk_pkg::CSR_GAP_UNITS: s.gap = val[3:0];
         default: ;
      endcase
   endfunction

   // 0 all dahs; 1..5 lead with that many dits; 6..9 lead with digit-5 dahs
   function automatic bit is_dah(logic [3:0] d, int e);
      if (d == 4'd0)
         return 1'b1;
      if (d <= 4'd5)
         return e >= int'(d);
      return e < int'(d) - 5;
   endfunction

   // a zero length still ends on the first tick, as count >= 0 always holds
   function automatic logic [mtdk_pkg::CNT_W-1:0] span(logic [15:0] dit, logic [3:0] units);
      return mtdk_pkg::CNT_W'(dit) * mtdk_pkg::CNT_W'(units);
   endfunction

   function automatic mtdk_pkg::mtdk_res_type keyer_advance(inout keyer_state_type s,
                                                            input keyer_item_type it);
      mtdk_pkg::mtdk_res_type r;
      logic [3:0][3:0]        nib;
      logic [3:0]             units;
      bit                     bad;
      r      = '0;
      nib[0] = 4'(it.hours[5:4]);
      nib[1] = it.hours[3:0];
      nib[2] = 4'(it.minutes[6:4]);
      nib[3] = it.minutes[3:0];
      bad    = 1'b0;
      for (int i = 0; i < 4; i++)
         if (nib[i] > 4'd9)
            bad = 1'b1;
      if (it.op == OP_START) begin
         if (s.phase != mtdk_pkg::PH_IDLE || bad) begin
            r.rejected = 1'b1;
         end else begin
            s.digits  = nib;
            s.phase   = mtdk_pkg::PH_MARK;
            s.count   = '0;
            s.element = '0;
            s.digit   = '0;
         end
      end else if (s.phase == mtdk_pkg::PH_MARK) begin
         s.count = s.count + 1'b1;
         units   = is_dah(s.digits[s.digit], int'(s.element)) ? s.dah : 4'd1;
         if (s.count >= span(s.dit, units)) begin
            s.phase = mtdk_pkg::PH_GAP;
            s.count = '0;
         end
      end else if (s.phase == mtdk_pkg::PH_GAP) begin
         s.count = s.count + 1'b1;
         if (s.count >= span(s.dit, s.gap)) begin
            s.count = '0;
            if (int'(s.element) + 1 < mtdk_pkg::ELEMENT_COUNT) begin
               s.element = s.element + 1'b1;
               s.phase   = mtdk_pkg::PH_MARK;
            end else if (int'(s.digit) + 1 < DIGITS) begin
               s.element = '0;
               s.digit   = s.digit + 1'b1;
               s.phase   = mtdk_pkg::PH_MARK;
            end else begin
               s.element = '0;
               s.digit   = '0;
               s.phase   = mtdk_pkg::PH_IDLE;
               r.done    = 1'b1;
            end
         end
      end
      r.key  = (s.phase == mtdk_pkg::PH_MARK);
      r.busy = (s.phase != mtdk_pkg::PH_IDLE);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : tx_drive
      keyer_item_type it;
      if (reset) begin
         req_valid   <= 1'b0;
         tx_gap_left <= 0;
      end else if (!req_valid || req_beat) begin
         if (tx_gap_left != 0) begin
            req_valid   <= 1'b0;
            tx_gap_left <= tx_gap_left - 1;
         end else if (items_to_send.size() != 0) begin
            it = items_to_send.pop_front();
            req_valid       <= 1'b1;
            req_op          <= it.op;
            req_hours_bcd   <= it.hours;
            req_minutes_bcd <= it.minutes;
            if ($urandom_range(0, 39) == 0)
               tx_burst = !tx_burst;
            tx_gap_left <= tx_burst ? 0 : $urandom_range(0, 16);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : accept_items
      keyer_item_type         it;
      mtdk_pkg::mtdk_res_type r;
      req_beat <= !reset && req_valid && !req_stall;
      if (!reset && csr_we)
         apply_timing(line_state, mtdk_pkg::csr_idx_type'(csr_index), csr_wdata);
      if (!reset && req_valid && !req_stall) begin
         it.op      = keyer_op_type'(req_op);
         it.hours   = req_hours_bcd;
         it.minutes = req_minutes_bcd;
         r = keyer_advance(line_state, it);
         results_due.push_back(r);
         if (r.rejected)
            starts_refused++;
         else if (it.op == OP_START)
            starts_taken++;
         if (r.done)
            sends_done++;
      end
   end

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : rx_hold
      if (rx_hold_start)
         rx_hold_left <= HOLD_CYCLES;
      else if (rx_hold_left != 0)
         rx_hold_left <= rx_hold_left - 1;
   end

   always @(negedge clock) begin : rx_pace
      int unsigned pause_n;
      if (reset) begin
         rsp_stall   <= 1'b0;
         rx_gap_left <= 0;
      end else begin
         if (rsp_beat) begin
            if ($urandom_range(0, 39) == 0)
               rx_burst = !rx_burst;
            pause_n = rx_burst ? 0 : $urandom_range(0, 16);
         end else begin
            pause_n = rx_gap_left;
         end
         rsp_stall   <= (rx_hold_left != 0) || (pause_n != 0);
         rx_gap_left <= (pause_n != 0) ? pause_n - 1 : 0;
      end
   end

   always @(posedge clock) begin : check_results
      mtdk_pkg::mtdk_res_type want;
      mtdk_pkg::mtdk_res_type got;
      rsp_beat <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_key, rsp_busy_res, rsp_done_res, rsp_rejected};
         if (results_due.size() == 0) begin
            error_count++;
            $display("%0t: result beat with nothing expected, got %b", $time, got);
         end else begin
            want = results_due.pop_front();
            for (int b = 3; b >= 0; b--)
               if (got[b] !== want[b]) begin
                  error_count++;
                  $display("%0t: result %0d %s expected %b got %b",
                           $time, results_seen, res_field[b], want[b], got[b]);
               end
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timed out with %0d results outstanding", $time, results_due.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   function automatic void queue_item(keyer_op_type op, logic [5:0] hours,
                                      logic [6:0] minutes);
      keyer_item_type it;
      it.op      = op;
      it.hours   = hours;
      it.minutes = minutes;
      void'(keyer_advance(plan_state, it));
      items_to_send.push_back(it);
      items_queued++;
   endfunction

   // every queued beat sent and its result checked
   task automatic wait_drained();
      while (items_to_send.size() != 0 || results_seen < items_queued)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_timing(mtdk_pkg::csr_idx_type idx, logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      apply_timing(plan_state, idx, val);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_phase(logic [15:0] dit, logic [3:0] dah, logic [3:0] gap,
                            int unsigned n, bit long_hold, bit mid_pause);
      int unsigned  roll;
      keyer_op_type op;
      logic [5:0]   hours;
      logic [6:0]   minutes;
      wait_drained();
      write_timing(mtdk_pkg::CSR_DIT_TICKS, dit);
      // upper data bits are don't-care for the 4-bit unit registers
      write_timing(mtdk_pkg::CSR_DAH_UNITS, {12'($urandom), dah});
      write_timing(mtdk_pkg::CSR_GAP_UNITS, {12'($urandom), gap});
      settings_run++;
      @(posedge clock);
      for (int i = 0; i < n; i++) begin
         if (mid_pause && i == n / 2) begin
            wait_drained();
            @(posedge clock);
         end
         roll    = $urandom_range(0, 99);
         op      = OP_TICK;
         hours   = 6'($urandom);
         minutes = 7'($urandom);
         if (plan_state.phase == mtdk_pkg::PH_IDLE) begin
            if (roll < 70) begin
               op      = OP_START;
               hours   = {2'($urandom_range(0, 3)), 4'($urandom_range(0, 9))};
               minutes = {3'($urandom_range(0, 7)), 4'($urandom_range(0, 9))};
            end else if (roll < 82) begin
               op = OP_START;   // random fields, often a nibble above nine
            end
         end else if (roll < 3) begin
            op = OP_START;
         end
         queue_item(op, hours, minutes);
      end
      if (long_hold) begin
         // sink holds off while the source keeps offering, so the core backs up
         @(posedge clock) rx_hold_start <= 1'b1;
         @(posedge clock) rx_hold_start <= 1'b0;
      end
   endtask

   initial begin : main_seq
      int unsigned ph_dit  [7] = '{1, 0, 2, 1, 65535, 1, 3};
      int unsigned ph_dah  [7] = '{3, 0, 1, 15, 15, 2, 1};
      int unsigned ph_gap  [7] = '{3, 0, 1, 1, 15, 15, 2};
      int unsigned ph_n    [7] = '{500, 350, 250, 300, 60, 350, 150};
      plan_state = idle_keyer();
      line_state = idle_keyer();
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // directed beats at the reset timing
      queue_item(OP_TICK,  6'h00, 7'h00);
      queue_item(OP_TICK,  6'h3F, 7'h7F);
      queue_item(OP_START, 6'h3F, 7'h7F);
      queue_item(OP_START, 6'h09, 7'h0A);
      queue_item(OP_START, 6'h1A, 7'h00);
      queue_item(OP_START, 6'h00, 7'h00);
      queue_item(OP_START, 6'h12, 7'h34);
      for (int i = 0; i < 5; i++)
         queue_item(OP_TICK, 6'($urandom), 7'($urandom));
      queue_item(OP_START, 6'h3F, 7'h7F);
      queue_item(OP_START, 6'h39, 7'h79);
      queue_item(OP_TICK,  6'h00, 7'h00);

      // later phases shorten or stretch the element in flight
      for (int p = 0; p < 7; p++)
         run_phase(16'(ph_dit[p]), 4'(ph_dah[p]), 4'(ph_gap[p]), ph_n[p],
                   p == 0 || p == 5, p == 2);

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Checked %0d result beats across %0d timing settings.",
               results_seen, settings_run);
      $display("Sequences started %0d, completed %0d; starts refused %0d.",
               starts_taken, sends_done, starts_refused);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
